/* rtl/throttle_filter_ramp_core_macros.svh */
// Assertion helpers, clocked on i_clk and disabled while i_rst_n is low.
`ifndef THROTTLE_FILTER_RAMP_CORE_MACROS_SVH
`define THROTTLE_FILTER_RAMP_CORE_MACROS_SVH

// Same-cycle implication.
`define TFR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tfr_pkg.sv */
package tfr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int DATA_W      = 16;
    localparam int ACC_W       = 2 * DATA_W;
    localparam int DIV_STEPS   = ACC_W;
    localparam int CNT_W       = $clog2(DIV_STEPS);
    localparam int STEP_W      = 15;
    localparam int CFG_IDX_W   = 2;

    localparam logic [DATA_W-1:0] INVALID_CODE = 16'hFFFF;
    localparam logic [DATA_W-1:0] SAMPLE_MASK  =
        DATA_W'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [CNT_W-1:0]  CNT_LAST     = CNT_W'(DIV_STEPS - 1);

    localparam logic [DATA_W-1:0] BW_RESET     = 16'd16;
    localparam logic [DATA_W-1:0] SLOPE_RESET  = 16'd1;
    localparam logic [DATA_W-1:0] OFFSET_RESET = 16'd0;
    localparam logic [STEP_W-1:0] STEP_RESET   = 15'd1;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_RAMP   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BANDWIDTH = 2'd0,
        REG_SLOPE     = 2'd1,
        REG_OFFSET    = 2'd2,
        REG_STEP      = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL,
        S_DIV,
        S_TGT,
        S_RAMP,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic mul;
        logic div_step;
        logic target;
        logic ramp;
        logic clear;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic invalid;
        logic div_last;
    } t_status;

endpackage

/* rtl/tfr_datapath.sv */
module tfr_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tfr_pkg::t_cmd                       i_cmd,
    output tfr_pkg::t_status                    o_status,
    input  logic [1:0]                          i_op,
    input  logic [tfr_pkg::DATA_W-1:0]          i_sample,
    input  logic                                i_cfg_we,
    input  logic [tfr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tfr_pkg::DATA_W-1:0]          i_cfg_data,
    output logic [tfr_pkg::DATA_W-1:0]          o_instant_value,
    output logic [tfr_pkg::DATA_W-1:0]          o_average_value,
    output logic signed [tfr_pkg::DATA_W-1:0]   o_current_reference
);

    logic [tfr_pkg::DATA_W-1:0]        r_bw;
    logic signed [tfr_pkg::DATA_W-1:0] r_slope;
    logic [tfr_pkg::DATA_W-1:0]        r_offset;
    logic [tfr_pkg::STEP_W-1:0]        r_step;

    tfr_pkg::t_op                      r_op;
    logic [tfr_pkg::DATA_W-1:0]        r_sample;
    logic [tfr_pkg::DATA_W-1:0]        r_last_raw;
    logic [tfr_pkg::DATA_W-1:0]        r_avg;
    logic [tfr_pkg::DATA_W-1:0]        r_ref;

    logic [tfr_pkg::ACC_W-1:0]         r_acc;
    logic [tfr_pkg::DATA_W:0]          r_rem;
    logic [tfr_pkg::CNT_W-1:0]         r_cnt;
    logic [tfr_pkg::DATA_W-1:0]        r_tgt;

    logic [tfr_pkg::DATA_W-1:0]        r_out_inst;
    logic [tfr_pkg::DATA_W-1:0]        r_out_avg;
    logic [tfr_pkg::DATA_W-1:0]        r_out_ref;

    logic [tfr_pkg::DATA_W-1:0]        w_bw_eff;
    logic [tfr_pkg::DATA_W-1:0]        w_bw_m1;
    logic [tfr_pkg::DATA_W-1:0]        w_s;
    logic [tfr_pkg::ACC_W-1:0]         w_prod;
    logic [tfr_pkg::ACC_W-1:0]         w_acc_init;
    logic [tfr_pkg::DATA_W:0]          w_rem_sh;
    logic                              w_ge;
    logic [tfr_pkg::DATA_W:0]          w_rem_nx;
    logic [tfr_pkg::ACC_W-1:0]         w_acc_nx;
    logic [tfr_pkg::DATA_W-1:0]        w_diff;
    logic [tfr_pkg::DATA_W-1:0]        w_tprod;
    logic [tfr_pkg::DATA_W-1:0]        w_step16;
    logic [tfr_pkg::DATA_W-1:0]        w_ref_nx;

    // zero bandwidth behaves as one
    assign w_bw_eff   = (r_bw == '0) ? tfr_pkg::DATA_W'(1) : r_bw;
    assign w_bw_m1    = w_bw_eff - tfr_pkg::DATA_W'(1);
    assign w_s        = r_sample & tfr_pkg::SAMPLE_MASK;
    assign w_prod     = {{tfr_pkg::DATA_W{1'b0}}, w_bw_m1} * {{tfr_pkg::DATA_W{1'b0}}, r_avg};
    assign w_acc_init = w_prod + {{tfr_pkg::DATA_W{1'b0}}, w_s};

    // restoring divider, one quotient bit per cycle
    assign w_rem_sh = {r_rem[tfr_pkg::DATA_W-1:0], r_acc[tfr_pkg::ACC_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, w_bw_eff};
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, w_bw_eff}) : w_rem_sh;
    assign w_acc_nx = {r_acc[tfr_pkg::ACC_W-2:0], w_ge};

    // only the low 16 bits of slope * (avg - offset) are kept
    assign w_diff   = r_avg - r_offset;
    assign w_tprod  = r_slope * w_diff;

    assign w_step16 = {1'b0, r_step};

    always_comb begin
        if (!r_tgt[tfr_pkg::DATA_W-1]) begin
            w_ref_nx = ($signed(r_tgt) > $signed(r_ref)) ? (r_ref + w_step16) : r_tgt;
        end else begin
            w_ref_nx = ($signed(r_tgt) < $signed(r_ref)) ? (r_ref - w_step16) : r_tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bw     <= tfr_pkg::BW_RESET;
            r_slope  <= tfr_pkg::SLOPE_RESET;
            r_offset <= tfr_pkg::OFFSET_RESET;
            r_step   <= tfr_pkg::STEP_RESET;
        end else if (i_cfg_we) begin
            case (tfr_pkg::t_reg'(i_cfg_index))
                tfr_pkg::REG_BANDWIDTH: r_bw     <= i_cfg_data;
                tfr_pkg::REG_SLOPE:     r_slope  <= i_cfg_data;
                tfr_pkg::REG_OFFSET:    r_offset <= i_cfg_data;
                tfr_pkg::REG_STEP:      r_step   <= i_cfg_data[tfr_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw <= '0;
            r_avg      <= '0;
            r_ref      <= '0;
        end else begin
            if (i_cmd.capture && (tfr_pkg::t_op'(i_op) == tfr_pkg::OP_SAMPLE)) begin
                r_last_raw <= i_sample;
            end
            if (i_cmd.div_step && (r_cnt == tfr_pkg::CNT_LAST)) begin
                r_avg <= w_acc_nx[tfr_pkg::DATA_W-1:0];
            end
            if (i_cmd.ramp) begin
                r_ref <= w_ref_nx;
            end
            if (i_cmd.clear) begin
                r_avg <= '0;
                r_ref <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= tfr_pkg::t_op'(i_op);
            r_sample <= i_sample;
        end
        if (i_cmd.mul) begin
            r_acc <= w_acc_init;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_acc <= w_acc_nx;
            r_rem <= w_rem_nx;
            r_cnt <= r_cnt + tfr_pkg::CNT_W'(1);
        end
        if (i_cmd.target) begin
            r_tgt <= w_tprod;
        end
        if (i_cmd.load_out) begin
            r_out_inst <= r_last_raw;
            r_out_avg  <= r_avg;
            r_out_ref  <= r_ref;
        end
    end

    assign o_status.op       = r_op;
    assign o_status.invalid  = (r_sample == tfr_pkg::INVALID_CODE);
    assign o_status.div_last = (r_cnt == tfr_pkg::CNT_LAST);

    assign o_instant_value     = r_out_inst;
    assign o_average_value     = r_out_avg;
    assign o_current_reference = r_out_ref;

endmodule

/* rtl/tfr_ctrl.sv */
`include "throttle_filter_ramp_core_macros.svh"

module tfr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  tfr_pkg::t_status  i_status,
    output tfr_pkg::t_cmd     o_cmd
);

    tfr_pkg::t_state r_state;
    tfr_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            tfr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = tfr_pkg::S_DISPATCH;
                end
            end
            tfr_pkg::S_DISPATCH: begin
                case (i_status.op)
                    tfr_pkg::OP_SAMPLE: begin
                        n_state = i_status.invalid ? tfr_pkg::S_FINISH : tfr_pkg::S_MUL;
                    end
                    tfr_pkg::OP_RAMP: n_state = tfr_pkg::S_TGT;
                    default:          n_state = tfr_pkg::S_FINISH;
                endcase
            end
            tfr_pkg::S_MUL: n_state = tfr_pkg::S_DIV;
            tfr_pkg::S_DIV: begin
                if (i_status.div_last) begin
                    n_state = tfr_pkg::S_FINISH;
                end
            end
            tfr_pkg::S_TGT:  n_state = tfr_pkg::S_RAMP;
            tfr_pkg::S_RAMP: n_state = tfr_pkg::S_FINISH;
            tfr_pkg::S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = tfr_pkg::S_IDLE;
                end
            end
            default: n_state = tfr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            tfr_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            tfr_pkg::S_DISPATCH: o_cmd.clear    = (i_status.op == tfr_pkg::OP_CLEAR);
            tfr_pkg::S_MUL:      o_cmd.mul      = 1'b1;
            tfr_pkg::S_DIV:      o_cmd.div_step = 1'b1;
            tfr_pkg::S_TGT:      o_cmd.target   = 1'b1;
            tfr_pkg::S_RAMP:     o_cmd.ramp     = 1'b1;
            tfr_pkg::S_FINISH:   o_cmd.load_out = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign n_out_valid = o_cmd.load_out || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tfr_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `TFR_ASSERT_NEXT(a_accept_dispatch, i_in_valid && o_in_ready, r_state == tfr_pkg::S_DISPATCH, "accepted transaction not dispatched")
    `TFR_ASSERT_NEXT(a_stall_hold, (r_state == tfr_pkg::S_FINISH) && r_out_valid && !i_out_ready, (r_state == tfr_pkg::S_FINISH) && r_out_valid, "stalled result lost")
    `TFR_ASSERT_NEXT(a_div_exit, (r_state == tfr_pkg::S_DIV) && i_status.div_last, r_state == tfr_pkg::S_FINISH, "divider did not finish")
    `TFR_ASSERT_NEXT(a_load_valid, o_cmd.load_out, r_out_valid && (r_state == tfr_pkg::S_IDLE), "loaded result not presented")
    `TFR_ASSERT_SAME(a_no_ready_busy, r_state != tfr_pkg::S_IDLE, !o_cmd.capture, "capture outside idle")

endmodule

/* rtl/throttle_filter_ramp_core.sv */
// Throttle conditioning and torque-current reference ramp.
// Input channel (i_in_valid / o_in_ready): i_op selects the event, 0 sample,
// 1 ramp tick, 2 clear average and reference, 3 no change; i_sample carries
// the raw conversion, 0xFFFF marking a missing one.
// Output channel (o_out_valid / i_out_ready): one result per input transaction,
// giving the stored raw value, the filtered level and the current reference.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 bandwidth, 1 slope, 2 offset, 3 ramp step); write only while idle.
// From acceptance, a valid sample passes through dispatch, a multiply-add
// and the restoring divider before the result is loaded; a ramp tick passes
// through dispatch, target and ramp steps; anything else goes from dispatch
// straight to the result. One transaction is in work at a time, and the
// next one is accepted in the cycle after the result is registered.
// The result sits in an output register; a new transaction is accepted while
// it waits, and if the receiver still stalls when the next result is ready,
// the block holds in its final state until the register frees.
// Synchronous active-low reset restores register defaults, clears the
// filtered level, reference and stored raw value, and drops o_out_valid.
module throttle_filter_ramp_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_op,
    input  logic [tfr_pkg::DATA_W-1:0]          i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tfr_pkg::DATA_W-1:0]          o_instant_value,
    output logic [tfr_pkg::DATA_W-1:0]          o_average_value,
    output logic signed [tfr_pkg::DATA_W-1:0]   o_current_reference,
    input  logic                                i_cfg_we,
    input  logic [tfr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tfr_pkg::DATA_W-1:0]          i_cfg_data
);

    tfr_pkg::t_cmd    w_cmd;
    tfr_pkg::t_status w_status;

    tfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tfr_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_op                (i_op),
        .i_sample            (i_sample),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_instant_value     (o_instant_value),
        .o_average_value     (o_average_value),
        .o_current_reference (o_current_reference)
    );

endmodule
